// ===== rtl/core/dtat_pkg.sv =====
package dtat_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DATE   = 2'd2,
        OP_TIME   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [7:0]  day_tag;
        logic [7:0]  handle;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [7:0]  event_type;
        logic [15:0] event_arg;
    } slot_t;

    typedef struct packed {
        logic load;       // capture the input beat, rewind the slot index
        logic day_inc;
        logic advance;
        logic add_write;
        logic issue;      // read the slot at the index for the match check
        logic flush;      // release the held result as the last one
    } cmd_t;

    typedef struct packed {
        logic free_here;
        logic idx_last;
    } stat_t;

endpackage

// ===== rtl/core/dtat_ctrl.sv =====
module dtat_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  dtat_pkg::stat_t  stat,
    output dtat_pkg::cmd_t   cmd,
    output logic             busy
);
    import dtat_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_ADD:    state_next = ST_ADD;
                        OP_REMOVE: state_next = ST_SCAN;
                        OP_DATE:   state_next = ST_IDLE;
                        OP_TIME:   state_next = ST_SCAN;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (stat.free_here || stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load    = accept;
                cmd.day_inc = accept && (op_t'(op) == OP_DATE);
            end
            ST_ADD:
            begin
                cmd.add_write = stat.free_here;
                cmd.advance   = !stat.free_here && !stat.idx_last;
            end
            ST_SCAN:
            begin
                cmd.issue   = 1'b1;
                cmd.advance = !stat.idx_last;
            end
            ST_DRAIN: cmd = '0;
            ST_FLUSH: cmd.flush = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/dtat_datapath.sv =====
module dtat_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  dtat_pkg::cmd_t   cmd,
    output dtat_pkg::stat_t  stat,
    input  logic [1:0]       op,
    input  logic [7:0]       handle,
    input  logic [4:0]       hour,
    input  logic [5:0]       minute,
    input  logic [7:0]       event_type,
    input  logic [15:0]      event_arg,
    output logic             fired,
    output logic [7:0]       fired_handle,
    output logic [7:0]       fired_type,
    output logic [15:0]      fired_arg,
    output logic             last
);
    import dtat_pkg::*;

    slot_t                 mem [SLOT_COUNT];
    slot_t                 rd_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     chk_idx_reg;
    logic                  chk_vld_reg;
    logic [7:0]            day_reg;

    op_t                   op_reg;
    logic [7:0]            handle_reg;
    logic [4:0]            hour_reg;
    logic [5:0]            minute_reg;
    logic [7:0]            type_reg;
    logic [15:0]           arg_reg;

    logic                  pend_vld_reg;
    slot_t                 pend_reg;

    logic                  hit_remove;
    logic                  hit_fire;

    assign stat.free_here = !valid_reg[idx_reg];
    assign stat.idx_last  = (idx_reg == SLOT_W'(SLOT_COUNT - 1));

    assign hit_remove = chk_vld_reg && (op_reg == OP_REMOVE) && valid_reg[chk_idx_reg]
                        && (rd_reg.handle == handle_reg);
    assign hit_fire   = chk_vld_reg && (op_reg == OP_TIME) && valid_reg[chk_idx_reg]
                        && (rd_reg.day_tag == day_reg) && (rd_reg.hour == hour_reg)
                        && (rd_reg.minute == minute_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            mem[idx_reg] <= '{day_tag: day_reg, handle: handle_reg, hour: hour_reg,
                              minute: minute_reg, event_type: type_reg,
                              event_arg: arg_reg};
        end
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(op);
            handle_reg <= handle;
            hour_reg   <= hour;
            minute_reg <= minute;
            type_reg   <= event_type;
            arg_reg    <= event_arg;
        end
        chk_idx_reg <= idx_reg;
        if (hit_fire)
        begin
            pend_reg <= rd_reg;
        end
        // a new hit releases the held one; the flush releases it as the last
        if ((hit_fire || cmd.flush) && pend_vld_reg)
        begin
            fired_handle <= pend_reg.handle;
            fired_type   <= pend_reg.event_type;
            fired_arg    <= pend_reg.event_arg;
            last         <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            day_reg      <= 8'd1;
            pend_vld_reg <= 1'b0;
            fired        <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= cmd.issue;
            fired       <= (hit_fire || cmd.flush) && pend_vld_reg;
            if (cmd.day_inc)
            begin
                day_reg <= day_reg + 8'd1;
            end
            priority if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.add_write)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (hit_remove || hit_fire)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end
            priority if (hit_fire)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_vld_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/day_tagged_alarm_table.sv =====
// Alarm table of SLOT_COUNT slots. Pulse start with busy low to issue one op:
// a date change leaves busy low; an add walks the slots from the lowest one
// until it finds a free one; a remove or a time change reads every slot once
// through the registered slot memory port. Fired events come out in slot
// order, each for exactly one cycle with fired high, at most one a cycle; the
// final event of a time change carries last. The receiver cannot stall the
// output, so it must take every fired beat. Reset clears the valid bits at
// once; no clearing pass is needed.
module day_tagged_alarm_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  handle,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [7:0]  event_type,
    input  logic [15:0] event_arg,
    output logic        fired,
    output logic [7:0]  fired_handle,
    output logic [7:0]  fired_type,
    output logic [15:0] fired_arg,
    output logic        last
);
    import dtat_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dtat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dtat_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .handle       (handle),
        .hour         (hour),
        .minute       (minute),
        .event_type   (event_type),
        .event_arg    (event_arg),
        .fired        (fired),
        .fired_handle (fired_handle),
        .fired_type   (fired_type),
        .fired_arg    (fired_arg),
        .last         (last)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dtat_pkg::*;

    localparam int LATENCY = SLOT_COUNT + 8;

    typedef struct packed {
        logic [7:0]  handle;
        logic [7:0]  ev_type;
        logic [15:0] ev_arg;
        logic        last;
    } alarm_event_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [7:0]  handle;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  event_type;
    logic [15:0] event_arg;
    logic        fired;
    logic [7:0]  fired_handle;
    logic [7:0]  fired_type;
    logic [15:0] fired_arg;
    logic        last;

    // shadow of the alarm table
    slot_t        alarm_slot [SLOT_COUNT];
    bit           alarm_live [SLOT_COUNT];
    logic [7:0]   today_tag;

    alarm_event_t pending_alarms[$];
    alarm_event_t next_alarm;
    int unsigned  mismatch_count;
    int unsigned  sender_idle_pct;

    day_tagged_alarm_table dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL day_tagged_alarm_table");
        $finish;
    end

    function automatic logic [7:0] random_handle();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
    endfunction

    function automatic logic [4:0] random_hour();
        return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(2));
    endfunction

    function automatic logic [5:0] random_minute();
        return ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(2));
    endfunction

    // random live slot that carries today's tag, or -1
    function automatic int due_slot();
        int hits[$];
        foreach (alarm_live[i])
        begin
            if (alarm_live[i] && alarm_slot[i].day_tag == today_tag)
                hits.push_back(i);
        end
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    task automatic update_alarm_table(input op_t code, input logic [7:0] h,
                                      input logic [4:0] hr, input logic [5:0] mn,
                                      input logic [7:0] et, input logic [15:0] ea);
        alarm_event_t hits[$];
        alarm_event_t ev;
        bit placed;
        placed = 1'b0;
        case (code)
            OP_ADD:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!placed && !alarm_live[i])
                    begin
                        alarm_live[i] = 1'b1;
                        alarm_slot[i] = '{day_tag: today_tag, handle: h, hour: hr,
                                          minute: mn, event_type: et, event_arg: ea};
                        placed = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (alarm_live[i] && alarm_slot[i].handle == h)
                        alarm_live[i] = 1'b0;
                end
            end
            OP_DATE:
                today_tag = today_tag + 8'd1;
            default:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (alarm_live[i] && alarm_slot[i].day_tag == today_tag &&
                        alarm_slot[i].hour == hr && alarm_slot[i].minute == mn)
                    begin
                        ev = '{handle: alarm_slot[i].handle, ev_type: alarm_slot[i].event_type,
                               ev_arg: alarm_slot[i].event_arg, last: 1'b0};
                        hits.push_back(ev);
                        alarm_live[i] = 1'b0;
                    end
                end
                foreach (hits[k])
                begin
                    ev = hits[k];
                    ev.last = (k == hits.size() - 1);
                    pending_alarms.push_back(ev);
                end
            end
        endcase
    endtask

    // drive one command beat and hold it until the block takes it
    task automatic send_item(input op_t code, input logic [7:0] h, input logic [4:0] hr,
                             input logic [5:0] mn, input logic [7:0] et,
                             input logic [15:0] ea);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(4, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start      <= 1'b1;
        op         <= code;
        handle     <= h;
        hour       <= hr;
        minute     <= mn;
        event_type <= et;
        event_arg  <= ea;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        update_alarm_table(code, h, hr, mn, et, ea);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_alarms.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && fired)
        begin
            if (pending_alarms.size() == 0)
            begin
                $error("fired_handle: expected no beat, got %0h", fired_handle);
                mismatch_count++;
            end
            else
            begin
                next_alarm = pending_alarms.pop_front();
                check_field("fired_handle", 16'(next_alarm.handle), 16'(fired_handle));
                check_field("fired_type", 16'(next_alarm.ev_type), 16'(fired_type));
                check_field("fired_arg", next_alarm.ev_arg, fired_arg);
                check_field("last", 16'(next_alarm.last), 16'(last));
            end
        end
    end

    task automatic test_directed();
        sender_idle_pct = 0;
        send_item(OP_TIME, 8'h00, 5'd0, 6'd0, 8'h00, 16'h0000);
        send_item(OP_ADD, 8'h00, 5'd0, 6'd0, 8'h00, 16'h0000);
        send_item(OP_ADD, 8'hff, 5'd23, 6'd59, 8'hff, 16'hffff);
        // out-of-range time is kept as raw bits
        send_item(OP_ADD, 8'ha5, 5'd31, 6'd63, 8'h5a, 16'ha55a);
        send_item(OP_TIME, 8'h3c, 5'd0, 6'd0, 8'hc3, 16'h1234);
        send_item(OP_TIME, 8'h00, 5'd23, 6'd59, 8'h00, 16'h0000);
        send_item(OP_TIME, 8'h00, 5'd31, 6'd63, 8'h00, 16'h0000);
        // remove drops every copy of a handle
        send_item(OP_ADD, 8'h42, 5'd5, 6'd5, 8'h01, 16'h0101);
        send_item(OP_ADD, 8'h42, 5'd5, 6'd5, 8'h02, 16'h0202);
        send_item(OP_ADD, 8'h43, 5'd5, 6'd5, 8'h03, 16'h0303);
        send_item(OP_REMOVE, 8'h42, 5'd17, 6'd41, 8'h99, 16'hbeef);
        send_item(OP_TIME, 8'h42, 5'd5, 6'd5, 8'h00, 16'h0000);
        // duplicate handles both fire
        send_item(OP_ADD, 8'h11, 5'd6, 6'd6, 8'h10, 16'h1000);
        send_item(OP_ADD, 8'h11, 5'd6, 6'd6, 8'h20, 16'h2000);
        send_item(OP_REMOVE, 8'h99, 5'd6, 6'd6, 8'h00, 16'h0000);
        send_item(OP_TIME, 8'h00, 5'd6, 6'd6, 8'h00, 16'h0000);
        send_item(OP_TIME, 8'h00, 5'd6, 6'd6, 8'h00, 16'h0000);
        // a slot from an earlier day never fires
        send_item(OP_ADD, 8'h20, 5'd8, 6'd0, 8'h77, 16'h7777);
        send_item(OP_DATE, 8'hff, 5'd31, 6'd63, 8'hff, 16'hffff);
        send_item(OP_TIME, 8'h20, 5'd8, 6'd0, 8'h00, 16'h0000);
        send_item(OP_REMOVE, 8'h20, 5'd0, 6'd0, 8'h00, 16'h0000);
        send_item(OP_TIME, 8'h20, 5'd8, 6'd0, 8'h00, 16'h0000);
    endtask

    task automatic test_table_full();
        logic [4:0] hr;
        logic [5:0] mn;
        sender_idle_pct = 7;
        hr = 5'($urandom_range(23));
        mn = 6'($urandom_range(59));
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (alarm_live[i])
                send_item(OP_REMOVE, alarm_slot[i].handle, random_hour(), random_minute(),
                          8'($urandom_range(255)), 16'($urandom_range(16'hffff)));
        end
        // overfill: the extra adds are dropped
        repeat (SLOT_COUNT + 2)
        begin
            send_item(OP_ADD, random_handle(), hr, mn, 8'($urandom_range(255)),
                      16'($urandom_range(16'hffff)));
        end
        send_item(OP_TIME, random_handle(), hr, mn, 8'($urandom_range(255)),
                  16'($urandom_range(16'hffff)));
    endtask

    task automatic test_day_wrap();
        sender_idle_pct = 0;
        send_item(OP_ADD, 8'h77, 5'd9, 6'd9, 8'h5e, 16'hc0de);
        // a full turn of the day tag brings the old slot back into range
        repeat (256)
            send_item(OP_DATE, random_handle(), random_hour(), random_minute(),
                      8'($urandom_range(255)), 16'($urandom_range(16'hffff)));
        send_item(OP_TIME, 8'h00, 5'd9, 6'd9, 8'h00, 16'h0000);
    endtask

    task automatic test_random_mix(input int unsigned idle_pct, input int unsigned items);
        int unsigned pick;
        int          target;
        op_t         code;
        logic [7:0]  h;
        logic [4:0]  hr;
        logic [5:0]  mn;
        sender_idle_pct = idle_pct;
        repeat (items)
        begin
            pick = $urandom_range(99);
            h    = random_handle();
            hr   = random_hour();
            mn   = random_minute();
            if (pick < 45)
                code = OP_ADD;
            else if (pick < 60)
                code = OP_REMOVE;
            else if (pick < 65)
                code = OP_DATE;
            else
                code = OP_TIME;
            // aim removes and time changes at a live slot half the time
            if (code != OP_ADD && $urandom_range(1) == 1)
            begin
                target = due_slot();
                if (target >= 0)
                begin
                    h  = alarm_slot[target].handle;
                    hr = alarm_slot[target].hour;
                    mn = alarm_slot[target].minute;
                end
            end
            send_item(code, h, hr, mn, 8'($urandom_range(255)), 16'($urandom_range(16'hffff)));
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        start           <= 1'b0;
        op              <= OP_ADD;
        handle          <= '0;
        hour            <= '0;
        minute          <= '0;
        event_type      <= '0;
        event_arg       <= '0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        today_tag       = 8'd1;
        foreach (alarm_live[i])
            alarm_live[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_quiet();
        test_table_full();
        wait_quiet();
        test_day_wrap();
        wait_quiet();
        test_random_mix(66, 10);
        wait_quiet();

        if (mismatch_count == 0)
            $display("PASS day_tagged_alarm_table");
        else
            $display("FAIL day_tagged_alarm_table");
        $finish;
    end

endmodule
